@@ src/prm_pkg.sv @@
// prm_pkg: opcodes, state encodings and fixed constants of the packet rate meter
// no dependencies; used by every module of the block
package prm_pkg;

	typedef enum logic [2:0] {
		OP_INC      = 3'd0,
		OP_RESET    = 3'd1,
		OP_OVERRULE = 3'd2,
		OP_CLICK    = 3'd3,
		OP_HOLD     = 3'd4,
		OP_CONTINUE = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_ELAPSED,
		F_APPLY
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL_LO,
		B_MUL_HI,
		B_SUM,
		B_CHECK,
		B_DIVIDE,
		B_ROUND,
		B_DONE
	} back_state_t;

	// field widths of the ports
	localparam int unsigned OP_W      = 3;
	localparam int unsigned IN_W      = 32;
	localparam int unsigned USEC_W    = 20;
	localparam int unsigned RATE_W    = 32;
	localparam int unsigned TIME_OUT_W = 48;

	// a timestamp in microseconds: (2^32 - 1) * 1e6 + 2^20 stays below 2^52
	localparam int unsigned STAMP_W = 52;

	localparam int unsigned US_PER_SEC    = 1000000;
	localparam int unsigned BITS_PER_BYTE = 8;

	// rate scale factors and the multiplier datapath built around them
	localparam int unsigned K_W   = 23;
	localparam logic [K_W-1:0] K_PKT = K_W'(US_PER_SEC);
	localparam logic [K_W-1:0] K_BIT = K_W'(US_PER_SEC * BITS_PER_BYTE);
	localparam int unsigned HALF_W  = 32;
	localparam int unsigned N_EXT_W = 2 * HALF_W;
	localparam int unsigned PROD_W  = HALF_W + K_W;
	localparam int unsigned NUM_W   = N_EXT_W + K_W;

	localparam int unsigned DIV_CNT_W = $clog2(RATE_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RATE_W - 1);

	localparam int unsigned QUEUE_DEPTH = 4;

endpackage

@@ src/packet_rate_meter.sv @@
// packet_rate_meter: top level, front (state update), snapshot queue, back (rates)
// depends on prm_pkg, prm_front, prm_fifo, prm_back
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  input    | in        | in_valid/in_stall  | opcode amount size_amount time_sec time_usec
//  result   | out       | out_valid/out_stall| packet_count byte_count total_time_us
//           |           |                    | packet_rate bit_rate is_running
//
// front accepts no new item until the last one's snapshot is pushed; back pops one
// snapshot at a time and runs two rates on one shared divider, each in 3 multiply/sum
// steps, 1 check, 32 quotient bits at one bit per cycle and 1 rounding step, ending at
// the check when the run time is zero or the rate saturates, plus pop and output load
// reset is asynchronous active low and clears counts, time, start stamp and running flag
// in_stall is high while the front is busy, also while it waits on a full queue;
// out_stall holds the result register and, once the queue fills, backs up to the input
module packet_rate_meter #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned TIME_WIDTH  = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [prm_pkg::OP_W-1:0]       opcode,
	input  logic [prm_pkg::IN_W-1:0]       amount,
	input  logic [prm_pkg::IN_W-1:0]       size_amount,
	input  logic [prm_pkg::IN_W-1:0]       time_sec,
	input  logic [prm_pkg::USEC_W-1:0]     time_usec,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [prm_pkg::RATE_W-1:0]     packet_count,
	output logic [prm_pkg::RATE_W-1:0]     byte_count,
	output logic [prm_pkg::TIME_OUT_W-1:0] total_time_us,
	output logic [prm_pkg::RATE_W-1:0]     packet_rate,
	output logic [prm_pkg::RATE_W-1:0]     bit_rate,
	output logic                           is_running
);
	import prm_pkg::*;

	localparam int unsigned SNAP_W = 2 * COUNT_WIDTH + TIME_WIDTH + 1;

	logic                   f_push, q_full, q_empty, b_pop;
	logic [COUNT_WIDTH-1:0] f_pkt, f_bytes;
	logic [TIME_WIDTH-1:0]  f_time;
	logic                   f_run;
	logic [SNAP_W-1:0]      q_wr, q_rd;

	prm_front #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.amount      (amount),
		.size_amount (size_amount),
		.time_sec    (time_sec),
		.time_usec   (time_usec),
		.q_push      (f_push),
		.q_full      (q_full),
		.q_pkt       (f_pkt),
		.q_bytes     (f_bytes),
		.q_time      (f_time),
		.q_run       (f_run)
	);

	assign q_wr = {f_run, f_time, f_bytes, f_pkt};

	prm_fifo #(
		.WIDTH (SNAP_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (b_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	prm_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (b_pop),
		.q_pkt         (q_rd[COUNT_WIDTH-1:0]),
		.q_bytes       (q_rd[2*COUNT_WIDTH-1:COUNT_WIDTH]),
		.q_time        (q_rd[2*COUNT_WIDTH+TIME_WIDTH-1:2*COUNT_WIDTH]),
		.q_run         (q_rd[SNAP_W-1]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.packet_count  (packet_count),
		.byte_count    (byte_count),
		.total_time_us (total_time_us),
		.packet_rate   (packet_rate),
		.bit_rate      (bit_rate),
		.is_running    (is_running)
	);

endmodule

@@ src/prm_front.sv @@
// prm_front: takes items, applies the opcode to the counters and the time
// accumulator, and pushes a snapshot of the new state into the queue; uses prm_pkg
module prm_front #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned TIME_WIDTH  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [prm_pkg::OP_W-1:0]     opcode,
	input  logic [prm_pkg::IN_W-1:0]     amount,
	input  logic [prm_pkg::IN_W-1:0]     size_amount,
	input  logic [prm_pkg::IN_W-1:0]     time_sec,
	input  logic [prm_pkg::USEC_W-1:0]   time_usec,
	output logic                         q_push,
	input  logic                         q_full,
	output logic [COUNT_WIDTH-1:0]       q_pkt,
	output logic [COUNT_WIDTH-1:0]       q_bytes,
	output logic [TIME_WIDTH-1:0]        q_time,
	output logic                         q_run
);
	import prm_pkg::*;

	localparam int unsigned SUM_W = ((STAMP_W > TIME_WIDTH) ? STAMP_W : TIME_WIDTH) + 1;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

	front_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] pkt_q, byte_q;
	logic [TIME_WIDTH-1:0]  run_time_q;
	logic [STAMP_W-1:0]     start_us_q;
	logic                   running_q;

	opcode_t                op_q;
	logic [IN_W-1:0]        amount_q, size_q;
	logic [STAMP_W-1:0]     stop_us_q, elapsed_q;

	logic [COUNT_WIDTH-1:0] pkt_d, byte_d;
	logic [TIME_WIDTH-1:0]  run_time_d, run_acc;
	logic [STAMP_W-1:0]     start_us_d;
	logic                   running_d;
	logic [SUM_W-1:0]       run_sum;
	logic                   accept;

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && !in_stall;

	// saturating add of the elapsed interval
	assign run_sum = SUM_W'(run_time_q) + SUM_W'(elapsed_q);
	assign run_acc = (run_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : run_sum[TIME_WIDTH-1:0];

	always_comb begin
		pkt_d      = pkt_q;
		byte_d     = byte_q;
		run_time_d = run_time_q;
		start_us_d = start_us_q;
		running_d  = running_q;
		case (op_q)
			OP_INC: begin
				pkt_d  = pkt_q + COUNT_WIDTH'(amount_q);
				byte_d = byte_q + COUNT_WIDTH'(size_q);
			end
			OP_RESET: begin
				pkt_d      = COUNT_WIDTH'(amount_q);
				byte_d     = '0;
				run_time_d = '0;
			end
			OP_OVERRULE: begin
				pkt_d  = COUNT_WIDTH'(amount_q);
				byte_d = COUNT_WIDTH'(size_q);
			end
			OP_CLICK: begin
				if (running_q) begin
					run_time_d = run_acc;
					start_us_d = stop_us_q;
				end
			end
			OP_HOLD: begin
				if (running_q) begin
					run_time_d = run_acc;
					start_us_d = stop_us_q;
					running_d  = 1'b0;
				end
			end
			OP_CONTINUE: begin
				if (!running_q) begin
					start_us_d = stop_us_q;
					running_d  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept)
					state_d = F_ELAPSED;
			end
			F_ELAPSED: state_d = F_APPLY;
			F_APPLY: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign q_pkt   = pkt_d;
	assign q_bytes = byte_d;
	assign q_time  = run_time_d;
	assign q_run   = running_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			pkt_q      <= '0;
			byte_q     <= '0;
			run_time_q <= '0;
			start_us_q <= '0;
			running_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_push) begin
				pkt_q      <= pkt_d;
				byte_q     <= byte_d;
				run_time_q <= run_time_d;
				start_us_q <= start_us_d;
				running_q  <= running_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode_t'(opcode);
			amount_q  <= amount;
			size_q    <= size_amount;
			// timestamp in microseconds, usec above one million simply adds on
			stop_us_q <= (STAMP_W'(time_sec) * STAMP_W'(US_PER_SEC)) + STAMP_W'(time_usec);
		end
		if (state_q == F_ELAPSED)
			elapsed_q <= (stop_us_q > start_us_q) ? (stop_us_q - start_us_q) : '0;
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full && $past(state_q) == F_ELAPSED || $past(state_q) == F_APPLY))
		else $error("snapshot pushed without a finished interval or into a full queue");
`endif

endmodule

@@ src/prm_fifo.sv @@
// prm_fifo: short queue of state snapshots between the front and the back
// depth from prm_pkg
module prm_fifo #(
	parameter int unsigned WIDTH = 113
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	import prm_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

`ifndef SYNTHESIS
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= (PTR_W + 1)'(QUEUE_DEPTH)) &&
		(PTR_W'(count_q) == PTR_W'(wr_ptr_q - rd_ptr_q)))
		else $error("queue fill count disagrees with pointers");
`endif

endmodule

@@ src/prm_back.sv @@
// prm_back: pops snapshots, scales counts and divides them by the run time
// bit by bit for both rates, and holds the result register; uses prm_pkg
module prm_back #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned TIME_WIDTH  = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  logic [COUNT_WIDTH-1:0]         q_pkt,
	input  logic [COUNT_WIDTH-1:0]         q_bytes,
	input  logic [TIME_WIDTH-1:0]          q_time,
	input  logic                           q_run,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [prm_pkg::RATE_W-1:0]     packet_count,
	output logic [prm_pkg::RATE_W-1:0]     byte_count,
	output logic [prm_pkg::TIME_OUT_W-1:0] total_time_us,
	output logic [prm_pkg::RATE_W-1:0]     packet_rate,
	output logic [prm_pkg::RATE_W-1:0]     bit_rate,
	output logic                           is_running
);
	import prm_pkg::*;

	localparam int unsigned CMP_W = ((TIME_WIDTH + RATE_W) > NUM_W) ?
		(TIME_WIDTH + RATE_W) : NUM_W;
	localparam int unsigned CNT_EXT_W  = (COUNT_WIDTH > RATE_W) ? COUNT_WIDTH : RATE_W;
	localparam int unsigned TIME_EXT_W = (TIME_WIDTH > TIME_OUT_W) ? TIME_WIDTH : TIME_OUT_W;

	back_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] job_pkt_q, job_byte_q;
	logic [TIME_WIDTH-1:0]  job_time_q;
	logic                   job_run_q;
	logic                   sel_q;
	logic [PROD_W-1:0]      plo_q, phi_q;
	logic [NUM_W-1:0]       num_q;
	logic [TIME_WIDTH:0]    rem_q;
	logic [RATE_W-1:0]      quo_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [RATE_W-1:0]      prate_q, brate_q;
	logic                   out_valid_q;

	logic [RATE_W-1:0]      packet_count_q, byte_count_q, packet_rate_q, bit_rate_q;
	logic [TIME_OUT_W-1:0]  total_time_q;
	logic                   is_running_q;

	logic [N_EXT_W-1:0]     n_sel;
	logic [K_W-1:0]         k_sel;
	logic [TIME_WIDTH:0]    trial;
	logic                   div_ge, too_big, round_up, finish, load_out;
	logic [RATE_W-1:0]      result;
	logic [CNT_EXT_W-1:0]   pkt_ext, byte_ext;
	logic [TIME_EXT_W-1:0]  time_ext;

	assign n_sel = sel_q ? N_EXT_W'(job_byte_q) : N_EXT_W'(job_pkt_q);
	assign k_sel = sel_q ? K_BIT : K_PKT;

	// quotient would need more than 32 bits
	assign too_big = CMP_W'(num_q) >= CMP_W'({job_time_q, {RATE_W{1'b0}}});

	assign trial    = {rem_q[TIME_WIDTH-1:0], quo_q[RATE_W-1]};
	assign div_ge   = trial >= {1'b0, job_time_q};
	assign round_up = {rem_q[TIME_WIDTH-1:0], 1'b0} >= {1'b0, job_time_q};

	assign pkt_ext  = CNT_EXT_W'(job_pkt_q);
	assign byte_ext = CNT_EXT_W'(job_byte_q);
	assign time_ext = TIME_EXT_W'(job_time_q);

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		finish   = 1'b0;
		result   = '0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_MUL_LO;
				end
			end
			B_MUL_LO: state_d = B_MUL_HI;
			B_MUL_HI: state_d = B_SUM;
			B_SUM:    state_d = B_CHECK;
			B_CHECK: begin
				if (job_time_q == '0) begin
					finish = 1'b1;
					result = '0;
				end else if (too_big) begin
					finish = 1'b1;
					result = '1;
				end else begin
					state_d = B_DIVIDE;
				end
			end
			B_DIVIDE: begin
				if (cnt_q == DIV_LAST)
					state_d = B_ROUND;
			end
			B_ROUND: begin
				finish = 1'b1;
				result = (round_up && quo_q != '1) ? quo_q + 1'b1 : quo_q;
			end
			B_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
		// packet rate first, then the bit rate on the same unit
		if (finish)
			state_d = sel_q ? B_DONE : B_MUL_LO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop)
				sel_q <= 1'b0;
			else if (finish)
				sel_q <= 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_pkt_q  <= q_pkt;
			job_byte_q <= q_bytes;
			job_time_q <= q_time;
			job_run_q  <= q_run;
		end
		if (state_q == B_MUL_LO)
			plo_q <= PROD_W'(n_sel[HALF_W-1:0]) * PROD_W'(k_sel);
		if (state_q == B_MUL_HI)
			phi_q <= PROD_W'(n_sel[N_EXT_W-1:HALF_W]) * PROD_W'(k_sel);
		if (state_q == B_SUM)
			num_q <= NUM_W'(plo_q) + (NUM_W'(phi_q) << HALF_W);
		if (state_q == B_CHECK) begin
			// upper part is below the divisor, low 32 bits feed the shifts
			rem_q <= (TIME_WIDTH + 1)'(num_q >> RATE_W);
			quo_q <= num_q[RATE_W-1:0];
			cnt_q <= '0;
		end
		if (state_q == B_DIVIDE) begin
			rem_q <= div_ge ? (trial - {1'b0, job_time_q}) : trial;
			quo_q <= {quo_q[RATE_W-2:0], div_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (finish && !sel_q)
			prate_q <= result;
		if (finish && sel_q)
			brate_q <= result;
		if (load_out) begin
			packet_count_q <= pkt_ext[RATE_W-1:0];
			byte_count_q   <= byte_ext[RATE_W-1:0];
			total_time_q   <= time_ext[TIME_OUT_W-1:0];
			packet_rate_q  <= prate_q;
			bit_rate_q     <= brate_q;
			is_running_q   <= job_run_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign packet_count  = packet_count_q;
	assign byte_count    = byte_count_q;
	assign total_time_us = total_time_q;
	assign packet_rate   = packet_rate_q;
	assign bit_rate      = bit_rate_q;
	assign is_running    = is_running_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIVIDE || state_q == B_ROUND) |-> (rem_q < {1'b0, job_time_q}))
		else $error("division remainder not below the run time");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIVIDE) |-> (job_time_q != '0))
		else $error("division started with zero run time");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!q_empty && state_q == B_IDLE))
		else $error("snapshot popped from empty queue or while busy");
`endif

endmodule
